// ===== rtl/flow_statistics_table_defines.svh =====
// Assertion macros shared by the flow statistics table RTL.
// No dependencies; included by files that carry assertions.
`ifndef FLOW_STATISTICS_TABLE_DEFINES_SVH
`define FLOW_STATISTICS_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define FST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fst_pkg.sv =====
// Package for the flow statistics table: sizes, codes, sequencer types.
// No dependencies; used by fst_divider and flow_statistics_table.
`default_nettype none
package fst_pkg;

   localparam int FLOW_ENTRIES = 16;
   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

   localparam int DIV_N_W    = 48;
   localparam int DIV_D_W    = 32;
   localparam int DIV_STEP_W = 6;

   localparam logic [1:0] FUNC_PACKET  = 2'd0;
   localparam logic [1:0] FUNC_CLEAR   = 2'd1;
   localparam logic [1:0] FUNC_READOUT = 2'd2;

   localparam logic [1:0] KIND_UPDATE = 2'd0;
   localparam logic [1:0] KIND_CREATE = 2'd1;
   localparam logic [1:0] KIND_DROP   = 2'd2;
   localparam logic [1:0] KIND_RECORD = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DEVIATE,
      ST_LOAD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DSEL_MEAN,
      DSEL_SIZE,
      DSEL_HOP,
      DSEL_IVL
   } div_sel_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_N_W-1:0]   dividend;
      logic [DIV_D_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_N_W-1:0]   quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/fst_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on fst_pkg for widths and the request/response structs.
`default_nettype none
module fst_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fst_pkg::div_req_type req,
   output fst_pkg::div_rsp_type      rsp
);

   logic [fst_pkg::DIV_D_W-1:0]    rem_ff, rem_in;
   logic [fst_pkg::DIV_N_W-1:0]    quo_ff, quo_in;
   logic [fst_pkg::DIV_D_W-1:0]    dsr_ff, dsr_in;
   logic [fst_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [fst_pkg::DIV_D_W:0]      rem_sh;
   logic [fst_pkg::DIV_D_W+1:0]    diff;
   logic                           ge;

   assign rem_sh = {rem_ff, quo_ff[fst_pkg::DIV_N_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign ge     = !diff[fst_pkg::DIV_D_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         step_in = fst_pkg::DIV_STEP_W'(fst_pkg::DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[fst_pkg::DIV_D_W-1:0] : rem_sh[fst_pkg::DIV_D_W-1:0];
         quo_in  = {quo_ff[fst_pkg::DIV_N_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == fst_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/flow_statistics_table.sv =====
// Per-source flow meter: a 16-flow table keyed by IPv6 source address.
// Channels: req_* (func, address, size, hop limit, tick) in, rsp_* records out,
// both valid/ready. req_ready is high only while the sequencer is idle; one
// item is worked on at a time.
// func packet: linear search, one entry per cycle, then an update, an insert
// or a drop, then one record with rsp_last set. func clear: empties the table, no record.
// func readout: one record per stored flow in insertion order, last marked.
// Every record but a drop needs three divides (size, hop, interval averages) in
// the shared divider; a hit adds one more for the running mean. The divider
// sets the rate.
// Reset empties the table (fill count to zero) and idles the sequencer.
// A stalled receiver holds the record in rsp_* registers; the block waits.
// Depends on fst_pkg, fst_divider and flow_statistics_table_defines.svh.
`default_nettype none
`include "flow_statistics_table_defines.svh"
module flow_statistics_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [63:0] req_src_addr_hi,
   input  wire logic [63:0] req_src_addr_lo,
   input  wire logic [15:0] req_pkt_size,
   input  wire logic [7:0]  req_hop_limit,
   input  wire logic [31:0] req_now_ticks,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [63:0]      rsp_flow_addr_hi,
   output logic [63:0]      rsp_flow_addr_lo,
   output logic [31:0]      rsp_packet_count,
   output logic [15:0]      rsp_avg_size,
   output logic [7:0]       rsp_avg_hop,
   output logic [31:0]      rsp_first_time,
   output logic [31:0]      rsp_last_time,
   output logic [31:0]      rsp_duration,
   output logic [31:0]      rsp_avg_interval,
   output logic [31:0]      rsp_max_dev_interval,
   output logic             rsp_last
);

   localparam int N = fst_pkg::FLOW_ENTRIES;

   // flow table, written only through the strobes below
   logic [63:0] ent_hi_ff   [N];
   logic [63:0] ent_lo_ff   [N];
   logic [31:0] ent_cnt_ff  [N];
   logic [47:0] ent_size_ff [N];
   logic [39:0] ent_hop_ff  [N];
   logic [31:0] ent_first_ff[N];
   logic [31:0] ent_last_ff [N];
   logic [31:0] ent_isum_ff [N];
   logic [31:0] ent_mdev_ff [N];

   fst_pkg::state_type   state_ff, state_in;
   fst_pkg::div_sel_type sel_ff, sel_in;
   logic [fst_pkg::CNT_W-1:0] used_ff, used_in;
   logic [fst_pkg::CNT_W-1:0] idx_ff, idx_in;

   // latched request
   logic [63:0] q_hi_ff, q_hi_in, q_lo_ff, q_lo_in;
   logic [15:0] q_size_ff, q_size_in;
   logic [7:0]  q_hop_ff, q_hop_in;
   logic [31:0] q_now_ff, q_now_in;

   logic [31:0] iv_ff, iv_in;
   logic [31:0] mean_ff, mean_in;

   // result record
   logic [1:0]  kind_ff, kind_in;
   logic [63:0] o_hi_ff, o_hi_in, o_lo_ff, o_lo_in;
   logic [31:0] o_cnt_ff, o_cnt_in;
   logic [15:0] o_asz_ff, o_asz_in;
   logic [7:0]  o_ahop_ff, o_ahop_in;
   logic [31:0] o_first_ff, o_first_in, o_last_ff, o_last_in;
   logic [31:0] o_dur_ff, o_dur_in, o_aiv_ff, o_aiv_in, o_mdev_ff, o_mdev_in;
   logic        o_lastf_ff, o_lastf_in;

   logic wr_new, wr_upd, wr_dev;
   logic [fst_pkg::IDX_W-1:0] ri;

   logic [63:0] e_hi, e_lo;
   logic [31:0] e_cnt, e_first, e_last, e_isum, e_mdev;
   logic [47:0] e_size;
   logic [39:0] e_hop;

   logic [31:0] ivl_now, cnt_new, isum_new, d_iv, d_mdev;
   logic [32:0] isum_sum;
   logic [48:0] size_sum;
   logic [40:0] hop_sum;

   fst_pkg::div_req_type div_req;
   fst_pkg::div_rsp_type div_rsp;

   assign ri      = idx_ff[fst_pkg::IDX_W-1:0];
   assign e_hi    = ent_hi_ff[ri];
   assign e_lo    = ent_lo_ff[ri];
   assign e_cnt   = ent_cnt_ff[ri];
   assign e_size  = ent_size_ff[ri];
   assign e_hop   = ent_hop_ff[ri];
   assign e_first = ent_first_ff[ri];
   assign e_last  = ent_last_ff[ri];
   assign e_isum  = ent_isum_ff[ri];
   assign e_mdev  = ent_mdev_ff[ri];

   // saturating accumulators for a hit
   assign ivl_now  = q_now_ff - e_last;
   assign cnt_new  = (e_cnt == 32'hFFFF_FFFF) ? e_cnt : e_cnt + 32'd1;
   assign size_sum = {1'b0, e_size} + {33'd0, q_size_ff};
   assign hop_sum  = {1'b0, e_hop} + {33'd0, q_hop_ff};
   assign isum_sum = {1'b0, e_isum} + {1'b0, ivl_now};
   assign isum_new = isum_sum[32] ? 32'hFFFF_FFFF : isum_sum[31:0];

   // distances to the running mean
   assign d_iv   = (iv_ff > mean_ff) ? iv_ff - mean_ff : mean_ff - iv_ff;
   assign d_mdev = (e_mdev > mean_ff) ? e_mdev - mean_ff : mean_ff - e_mdev;

   always_comb begin
      div_req.start   = (state_ff == fst_pkg::ST_DIV_GO);
      div_req.divisor = e_cnt;
      unique case (sel_ff)
         fst_pkg::DSEL_SIZE: div_req.dividend = e_size;
         fst_pkg::DSEL_HOP:  div_req.dividend = {8'd0, e_hop};
         fst_pkg::DSEL_MEAN,
         fst_pkg::DSEL_IVL:  div_req.dividend = {16'd0, e_isum};
         default:            div_req.dividend = {16'd0, e_isum};
      endcase
   end

   fst_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      used_in    = used_ff;
      idx_in     = idx_ff;
      q_hi_in    = q_hi_ff;
      q_lo_in    = q_lo_ff;
      q_size_in  = q_size_ff;
      q_hop_in   = q_hop_ff;
      q_now_in   = q_now_ff;
      iv_in      = iv_ff;
      mean_in    = mean_ff;
      kind_in    = kind_ff;
      o_hi_in    = o_hi_ff;
      o_lo_in    = o_lo_ff;
      o_cnt_in   = o_cnt_ff;
      o_asz_in   = o_asz_ff;
      o_ahop_in  = o_ahop_ff;
      o_first_in = o_first_ff;
      o_last_in  = o_last_ff;
      o_dur_in   = o_dur_ff;
      o_aiv_in   = o_aiv_ff;
      o_mdev_in  = o_mdev_ff;
      o_lastf_in = o_lastf_ff;
      wr_new     = 1'b0;
      wr_upd     = 1'b0;
      wr_dev     = 1'b0;

      unique case (state_ff)
         fst_pkg::ST_IDLE: begin
            if (req_valid) begin
               q_hi_in   = req_src_addr_hi;
               q_lo_in   = req_src_addr_lo;
               q_size_in = req_pkt_size;
               q_hop_in  = req_hop_limit;
               q_now_in  = req_now_ticks;
               idx_in    = '0;
               unique case (req_func)
                  fst_pkg::FUNC_PACKET: state_in = fst_pkg::ST_SEARCH;
                  fst_pkg::FUNC_CLEAR:  used_in  = '0;
                  fst_pkg::FUNC_READOUT: begin
                     if (used_ff != '0) begin
                        kind_in  = fst_pkg::KIND_RECORD;
                        state_in = fst_pkg::ST_LOAD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         fst_pkg::ST_SEARCH: begin
            priority if (idx_ff == used_ff) begin
               if (used_ff < fst_pkg::CNT_W'(N)) begin
                  // miss with room: insert at the fill mark
                  wr_new   = 1'b1;
                  used_in  = used_ff + 1'b1;
                  kind_in  = fst_pkg::KIND_CREATE;
                  state_in = fst_pkg::ST_LOAD;
               end else begin
                  kind_in    = fst_pkg::KIND_DROP;
                  o_hi_in    = q_hi_ff;
                  o_lo_in    = q_lo_ff;
                  o_cnt_in   = '0;
                  o_asz_in   = '0;
                  o_ahop_in  = '0;
                  o_first_in = '0;
                  o_last_in  = '0;
                  o_dur_in   = '0;
                  o_aiv_in   = '0;
                  o_mdev_in  = '0;
                  o_lastf_in = 1'b1;
                  state_in   = fst_pkg::ST_OUT;
               end
            end else if (e_hi == q_hi_ff && e_lo == q_lo_ff) begin
               kind_in  = fst_pkg::KIND_UPDATE;
               state_in = fst_pkg::ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         fst_pkg::ST_UPDATE: begin
            wr_upd   = 1'b1;
            iv_in    = ivl_now;
            sel_in   = fst_pkg::DSEL_MEAN;
            state_in = fst_pkg::ST_DIV_GO;
         end
         fst_pkg::ST_DIV_GO: begin
            state_in = fst_pkg::ST_DIV_WAIT;
         end
         fst_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (sel_ff)
                  fst_pkg::DSEL_MEAN: begin
                     mean_in  = div_rsp.quotient[31:0];
                     state_in = fst_pkg::ST_DEVIATE;
                  end
                  fst_pkg::DSEL_SIZE: begin
                     o_asz_in = (div_rsp.quotient[47:16] != '0) ? 16'hFFFF
                                                               : div_rsp.quotient[15:0];
                     sel_in   = fst_pkg::DSEL_HOP;
                     state_in = fst_pkg::ST_DIV_GO;
                  end
                  fst_pkg::DSEL_HOP: begin
                     o_ahop_in = (div_rsp.quotient[47:8] != '0) ? 8'hFF
                                                               : div_rsp.quotient[7:0];
                     sel_in    = fst_pkg::DSEL_IVL;
                     state_in  = fst_pkg::ST_DIV_GO;
                  end
                  fst_pkg::DSEL_IVL: begin
                     o_aiv_in = div_rsp.quotient[31:0];
                     state_in = fst_pkg::ST_OUT;
                  end
                  default: state_in = fst_pkg::ST_IDLE;
               endcase
            end
         end
         fst_pkg::ST_DEVIATE: begin
            wr_dev   = (d_iv > d_mdev);
            state_in = fst_pkg::ST_LOAD;
         end
         fst_pkg::ST_LOAD: begin
            o_hi_in    = e_hi;
            o_lo_in    = e_lo;
            o_cnt_in   = e_cnt;
            o_first_in = e_first;
            o_last_in  = e_last;
            o_dur_in   = e_last - e_first;
            o_mdev_in  = e_mdev;
            o_lastf_in = (kind_ff != fst_pkg::KIND_RECORD) || (idx_ff + 1'b1 == used_ff);
            sel_in     = fst_pkg::DSEL_SIZE;
            state_in   = fst_pkg::ST_DIV_GO;
         end
         fst_pkg::ST_OUT: begin
            if (rsp_ready) begin
               if (kind_ff == fst_pkg::KIND_RECORD && !o_lastf_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = fst_pkg::ST_LOAD;
               end else begin
                  state_in = fst_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = fst_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fst_pkg::ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff     <= sel_in;
      idx_ff     <= idx_in;
      q_hi_ff    <= q_hi_in;
      q_lo_ff    <= q_lo_in;
      q_size_ff  <= q_size_in;
      q_hop_ff   <= q_hop_in;
      q_now_ff   <= q_now_in;
      iv_ff      <= iv_in;
      mean_ff    <= mean_in;
      kind_ff    <= kind_in;
      o_hi_ff    <= o_hi_in;
      o_lo_ff    <= o_lo_in;
      o_cnt_ff   <= o_cnt_in;
      o_asz_ff   <= o_asz_in;
      o_ahop_ff  <= o_ahop_in;
      o_first_ff <= o_first_in;
      o_last_ff  <= o_last_in;
      o_dur_ff   <= o_dur_in;
      o_aiv_ff   <= o_aiv_in;
      o_mdev_ff  <= o_mdev_in;
      o_lastf_ff <= o_lastf_in;
   end

   // table writes
   always_ff @(posedge clock) begin
      if (wr_new) begin
         ent_hi_ff[ri]    <= q_hi_ff;
         ent_lo_ff[ri]    <= q_lo_ff;
         ent_cnt_ff[ri]   <= 32'd1;
         ent_size_ff[ri]  <= {32'd0, q_size_ff};
         ent_hop_ff[ri]   <= {32'd0, q_hop_ff};
         ent_first_ff[ri] <= q_now_ff;
         ent_last_ff[ri]  <= q_now_ff;
         ent_isum_ff[ri]  <= '0;
         ent_mdev_ff[ri]  <= '0;
      end
      if (wr_upd) begin
         ent_cnt_ff[ri]  <= cnt_new;
         ent_size_ff[ri] <= size_sum[48] ? 48'hFFFF_FFFF_FFFF : size_sum[47:0];
         ent_hop_ff[ri]  <= hop_sum[40] ? 40'hFF_FFFF_FFFF : hop_sum[39:0];
         ent_isum_ff[ri] <= isum_new;
         ent_last_ff[ri] <= q_now_ff;
      end
      if (wr_dev) begin
         ent_mdev_ff[ri] <= iv_ff;
      end
   end

   assign req_ready            = (state_ff == fst_pkg::ST_IDLE);
   assign rsp_valid            = (state_ff == fst_pkg::ST_OUT);
   assign rsp_kind             = kind_ff;
   assign rsp_flow_addr_hi     = o_hi_ff;
   assign rsp_flow_addr_lo     = o_lo_ff;
   assign rsp_packet_count     = o_cnt_ff;
   assign rsp_avg_size         = o_asz_ff;
   assign rsp_avg_hop          = o_ahop_ff;
   assign rsp_first_time       = o_first_ff;
   assign rsp_last_time        = o_last_ff;
   assign rsp_duration         = o_dur_ff;
   assign rsp_avg_interval     = o_aiv_ff;
   assign rsp_max_dev_interval = o_mdev_ff;
   assign rsp_last             = o_lastf_ff;

   `FST_ASSERT_NOW(a_fill_bound, 1'b1, used_ff <= fst_pkg::CNT_W'(N), "fill count past table size")
   `FST_ASSERT_NOW(a_div_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
   `FST_ASSERT_NOW(a_div_nonzero, div_req.start, div_req.divisor != '0, "divide by zero count")
   `FST_ASSERT_NEXT(a_clear_empties, req_valid && req_ready && req_func == fst_pkg::FUNC_CLEAR, used_ff == '0, "clear left flows")

endmodule
`default_nettype wire

// ===== tb/flow_statistics_table_tb.sv =====
// Testbench for flow_statistics_table: directed, saturation, back-pressure and random tests.
// Needs fst_pkg and the flow_statistics_table RTL; a built-in flow table predicts every record.
`timescale 1ns / 1ps
`default_nettype none
module flow_statistics_table_tb;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;   // code with no meaning, must be ignored
   localparam int CYCLE_LIMIT = 8000000;
   localparam int DRAIN_CYCLES = 400;           // longer than one packet's latency

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [31:0] count;
      logic [15:0] avg_size;
      logic [7:0]  avg_hop;
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic [31:0] duration;
      logic [31:0] avg_interval;
      logic [31:0] max_dev;
      logic        last;
   } flow_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [63:0] req_src_addr_hi = '0;
   logic [63:0] req_src_addr_lo = '0;
   logic [15:0] req_pkt_size = '0;
   logic [7:0]  req_hop_limit = '0;
   logic [31:0] req_now_ticks = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [63:0] rsp_flow_addr_hi;
   logic [63:0] rsp_flow_addr_lo;
   logic [31:0] rsp_packet_count;
   logic [15:0] rsp_avg_size;
   logic [7:0]  rsp_avg_hop;
   logic [31:0] rsp_first_time;
   logic [31:0] rsp_last_time;
   logic [31:0] rsp_duration;
   logic [31:0] rsp_avg_interval;
   logic [31:0] rsp_max_dev_interval;
   logic        rsp_last;

   flow_statistics_table dut (.*);

   always #2 clock = ~clock;

   // shadow flow table
   logic        tbl_valid    [fst_pkg::FLOW_ENTRIES];
   logic [63:0] tbl_hi       [fst_pkg::FLOW_ENTRIES];
   logic [63:0] tbl_lo       [fst_pkg::FLOW_ENTRIES];
   logic [31:0] tbl_count    [fst_pkg::FLOW_ENTRIES];
   logic [47:0] tbl_size_sum [fst_pkg::FLOW_ENTRIES];
   logic [39:0] tbl_hop_sum  [fst_pkg::FLOW_ENTRIES];
   logic [31:0] tbl_first    [fst_pkg::FLOW_ENTRIES];
   logic [31:0] tbl_last     [fst_pkg::FLOW_ENTRIES];
   logic [31:0] tbl_ivl_sum  [fst_pkg::FLOW_ENTRIES];
   logic [31:0] tbl_max_dev  [fst_pkg::FLOW_ENTRIES];
   int          tbl_used = 0;

   flow_record_type pending_records[$];
   int          errors = 0;
   int          cycles = 0;
   logic [31:0] cur_ticks = '0;
   bit          no_idle = 0;       // sender runs back to back
   int          hold_off_cycles = 0;  // receiver long stall request
   logic [63:0] addr_pool_hi[32];
   logic [63:0] addr_pool_lo[32];

   // append one expected record at the tail
   function automatic void queue_record(flow_record_type r);
      pending_records.insert(pending_records.size(), r);
   endfunction

   function automatic flow_record_type flow_record(int e, logic [1:0] kind, logic last);
      flow_record_type r;
      logic [63:0] n, q;
      n = (tbl_count[e] != 0) ? 64'(tbl_count[e]) : 64'd1;
      r.kind = kind;
      r.addr_hi = tbl_hi[e];
      r.addr_lo = tbl_lo[e];
      r.count = tbl_count[e];
      q = 64'(tbl_size_sum[e]) / n;
      r.avg_size = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      q = 64'(tbl_hop_sum[e]) / n;
      r.avg_hop = (q > 64'hFF) ? 8'hFF : q[7:0];
      r.first_time = tbl_first[e];
      r.last_time = tbl_last[e];
      r.duration = tbl_last[e] - tbl_first[e];
      q = 64'(tbl_ivl_sum[e]) / n;
      r.avg_interval = q[31:0];
      r.max_dev = tbl_max_dev[e];
      r.last = last;
      return r;
   endfunction

   function automatic logic [31:0] distance(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Advance the shadow table by one accepted item and queue its records.
   function automatic void predict_flow_item(logic [1:0] func, logic [63:0] hi,
         logic [63:0] lo, logic [15:0] size, logic [7:0] hop, logic [31:0] now);
      int e, hit, total, n;
      logic [31:0] ivl, mean;
      logic [64:0] s;
      flow_record_type r;
      hit = -1;
      total = 0;
      n = 0;
      unique case (func)
         fst_pkg::FUNC_CLEAR: begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            tbl_used = 0;
         end
         fst_pkg::FUNC_READOUT: begin
            foreach (tbl_valid[i]) if (tbl_valid[i]) total++;
            foreach (tbl_valid[i])
               if (tbl_valid[i]) begin
                  n++;
                  queue_record(flow_record(i, fst_pkg::KIND_RECORD, n == total));
               end
         end
         fst_pkg::FUNC_PACKET: begin
            for (e = 0; e < fst_pkg::FLOW_ENTRIES; e++)
               if (hit < 0 && tbl_valid[e] && tbl_hi[e] == hi && tbl_lo[e] == lo) hit = e;
            if (hit >= 0) begin
               e = hit;
               ivl = now - tbl_last[e];
               if (tbl_count[e] != 32'hFFFF_FFFF) tbl_count[e]++;
               s = 65'(tbl_size_sum[e]) + 65'(size);
               tbl_size_sum[e] = (s > 65'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
               s = 65'(tbl_hop_sum[e]) + 65'(hop);
               tbl_hop_sum[e] = (s > 65'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
               s = 65'(tbl_ivl_sum[e]) + 65'(ivl);
               tbl_ivl_sum[e] = (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
               tbl_last[e] = now;
               mean = tbl_ivl_sum[e] / ((tbl_count[e] != 0) ? tbl_count[e] : 32'd1);
               if (distance(ivl, mean) > distance(tbl_max_dev[e], mean))
                  tbl_max_dev[e] = ivl;
               queue_record(flow_record(e, fst_pkg::KIND_UPDATE, 1'b1));
            end else if (tbl_used < fst_pkg::FLOW_ENTRIES) begin
               e = tbl_used;
               tbl_used++;
               tbl_valid[e] = 1'b1;
               tbl_hi[e] = hi;
               tbl_lo[e] = lo;
               tbl_count[e] = 32'd1;
               tbl_size_sum[e] = 48'(size);
               tbl_hop_sum[e] = 40'(hop);
               tbl_first[e] = now;
               tbl_last[e] = now;
               tbl_ivl_sum[e] = '0;
               tbl_max_dev[e] = '0;
               queue_record(flow_record(e, fst_pkg::KIND_CREATE, 1'b1));
            end else begin
               r = '0;
               r.kind = fst_pkg::KIND_DROP;
               r.addr_hi = hi;
               r.addr_lo = lo;
               r.last = 1'b1;
               queue_record(r);
            end
         end
         default: ;  // unused code: no record, table untouched
      endcase
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one item from a falling edge, wait for the handshake, then maybe idle.
   task automatic send_item(logic [1:0] func, logic [63:0] hi, logic [63:0] lo,
         logic [15:0] size, logic [7:0] hop, logic [31:0] now);
      int gap;
      req_func = func;
      req_src_addr_hi = hi;
      req_src_addr_lo = lo;
      req_pkt_size = size;
      req_hop_limit = hop;
      req_now_ticks = now;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_flow_item(func, hi, lo, size, hop, now);
      @(negedge clock);
      gap = no_idle ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_packet(logic [63:0] hi, logic [63:0] lo, logic [31:0] step);
      cur_ticks += step;
      send_item(fst_pkg::FUNC_PACKET, hi, lo, 16'($urandom), 8'($urandom), cur_ticks);
   endtask

   task automatic send_ctrl(logic [1:0] func);
      // control items carry random don't-care fields
      send_item(func, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                8'($urandom), $urandom);
   endtask

   // sender pause: hold valid low until every record has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_records.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_ctrl(fst_pkg::FUNC_READOUT);          // empty table: no record
      send_ctrl(FUNC_UNUSED);                    // ignored
      cur_ticks = 32'hFFFF_FFF0;
      send_item(fst_pkg::FUNC_PACKET, '0, '0, 16'h0000, 8'h00, cur_ticks);
      send_item(fst_pkg::FUNC_PACKET, '1, '1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      // hits across the tick wrap
      send_item(fst_pkg::FUNC_PACKET, '1, '1, 16'hFFFF, 8'hFF, 32'h0000_0005);
      send_item(fst_pkg::FUNC_PACKET, '0, '0, 16'hFFFF, 8'hFF, 32'h0000_0005);
      send_item(fst_pkg::FUNC_PACKET, '1, '1, 16'h0001, 8'h01, 32'h0000_0100);
      // same hi, different lo must not hit
      send_item(fst_pkg::FUNC_PACKET, '1, 64'h1, 16'h1234, 8'h40, 32'h0000_0200);
      cur_ticks = 32'h0000_0200;
      send_ctrl(fst_pkg::FUNC_READOUT);
      // fill to the last slot, then drop, then hit on a full table
      while (tbl_used < fst_pkg::FLOW_ENTRIES)
         send_packet({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 50));
      send_packet({$urandom, $urandom}, {$urandom, $urandom}, 3);
      send_packet('1, '1, 7);
      send_ctrl(fst_pkg::FUNC_READOUT);
      send_ctrl(fst_pkg::FUNC_CLEAR);
      send_ctrl(fst_pkg::FUNC_READOUT);
      send_packet('0, '0, 1);           // re-created after clear
      wait_drained();
   endtask

   task automatic test_interval_saturation();
      logic [63:0] hi, lo;
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      send_ctrl(fst_pkg::FUNC_CLEAR);
      send_packet(hi, lo, 1);
      repeat (5) send_packet(hi, lo, 32'hF000_0000);   // interval sum pins at max
      send_packet(hi, lo, 0);
      send_ctrl(fst_pkg::FUNC_READOUT);
      wait_drained();
   endtask

   task automatic test_backpressure();
      int k;
      hold_off_cycles = 3000;
      for (k = 0; k < 6; k++)
         send_packet(addr_pool_hi[k], addr_pool_lo[k], $urandom_range(1, 1000));
      send_ctrl(fst_pkg::FUNC_READOUT);
      wait_drained();
   endtask

   task automatic test_random(int n_items);
      int k, r, slot;
      for (k = 0; k < 32; k++) begin
         addr_pool_hi[k] = {$urandom, $urandom};
         addr_pool_lo[k] = {$urandom, $urandom};
      end
      for (k = 0; k < n_items; k++) begin
         if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         // pool of 20 keeps hits common and occasionally overflows the table
         slot = $urandom_range(0, 19);
         if (r < 78)
            send_packet(addr_pool_hi[slot], addr_pool_lo[slot],
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300));
         else if (r < 84)
            send_packet({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 20));
         else if (r < 91) send_ctrl(fst_pkg::FUNC_READOUT);
         else if (r < 97) send_ctrl(fst_pkg::FUNC_CLEAR);
         else send_ctrl(FUNC_UNUSED);
      end
      no_idle = 0;
      wait_drained();
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         stall = idle_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp, act);
         errors++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      flow_record_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected record, kind %0d addr %h_%h", $realtime, rsp_kind,
                     rsp_flow_addr_hi, rsp_flow_addr_lo);
            errors++;
         end else begin
            exp = pending_records.pop_front();
            check_field("kind", 64'(exp.kind), 64'(rsp_kind));
            check_field("flow_addr_hi", exp.addr_hi, rsp_flow_addr_hi);
            check_field("flow_addr_lo", exp.addr_lo, rsp_flow_addr_lo);
            check_field("packet_count", 64'(exp.count), 64'(rsp_packet_count));
            check_field("avg_size", 64'(exp.avg_size), 64'(rsp_avg_size));
            check_field("avg_hop", 64'(exp.avg_hop), 64'(rsp_avg_hop));
            check_field("first_time", 64'(exp.first_time), 64'(rsp_first_time));
            check_field("last_time", 64'(exp.last_time), 64'(rsp_last_time));
            check_field("duration", 64'(exp.duration), 64'(rsp_duration));
            check_field("avg_interval", 64'(exp.avg_interval), 64'(rsp_avg_interval));
            check_field("max_dev_interval", 64'(exp.max_dev), 64'(rsp_max_dev_interval));
            check_field("last", 64'(exp.last), 64'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_interval_saturation();
      test_random(200);
      test_backpressure();
      test_random(230);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending_records.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
